FILE: rtl/art_pkg.sv
package art_pkg;

  localparam int IndexW = 6;
  localparam int WordW  = 64;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_FIND    = 2'd2,
    MODE_REGION  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    mode_e              mode;
    logic [WordW-1:0]   addr;
    logic [WordW-1:0]   chunk_size;
    logic [WordW-1:0]   region_end;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic               hit;
    logic [IndexW-1:0]  chunk_index;
    logic [WordW-1:0]   found_start;
    logic [WordW-1:0]   found_size;
    logic               region_busy;
  } out_item_t;

endpackage

FILE: rtl/art_in_if.sv
interface art_in_if;
  import art_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/art_out_if.sv
interface art_out_if;
  import art_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/allocated_region_table.sv
// Recording an allocation passes through the link update states LINK1, LINK2 and LINK3
// before its result is loaded in FINISH. Find and region query walk the allocated list one
// record at a time; a release adds the link update states LINK1 to LINK3 after its walk. A
// result is loaded only when the output has room, and no new input is taken until then.
// After reset a clearing pass over all CHUNK_COUNT records rebuilds the free chain in the link
// memories; no input transfer is taken until it ends.
module allocated_region_table #(
  parameter int CHUNK_COUNT = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  art_in_if.sink     in_i,
  art_out_if.source  out_o
);
  import art_pkg::*;

  localparam int LinkW = $clog2(CHUNK_COUNT + 1);
  localparam int AddrW = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
  localparam logic [LinkW-1:0] Nil      = LinkW'(CHUNK_COUNT);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(CHUNK_COUNT - 1);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_WALK   = 7'b0000100,
    S_LINK1  = 7'b0001000,
    S_LINK2  = 7'b0010000,
    S_LINK3  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_e;

  function automatic logic link_ok(logic [LinkW-1:0] link);
    return link < Nil;
  endfunction

  state_e            state_q, state_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [LinkW-1:0]  alloc_head_q, alloc_head_d;
  logic [LinkW-1:0]  free_head_q, free_head_d;
  logic [LinkW-1:0]  cur_q, cur_d;
  status_e           status_q, status_d;
  logic              hit_q, hit_d;
  logic              busy_q, busy_d;
  logic              out_valid_q, out_valid_d;
  in_item_t          item_q, item_d;
  out_item_t         out_item_q, out_item_d;

  // Record memory ports.
  logic              data_we;
  logic              next_we, prev_we;
  logic [AddrW-1:0]  next_waddr, prev_waddr;
  logic [LinkW-1:0]  next_wdata, prev_wdata;
  logic              rd_en;
  logic [AddrW-1:0]  rd_addr;
  logic [WordW-1:0]  rd_start, rd_len;
  logic [LinkW-1:0]  rd_next, rd_prev;

  // Shared compare unit for the list walk.
  logic [WordW-1:0]  walk_end;
  logic              contains, in_region, match;

  // Link update operands: unlink cur from one list, push it on the other.
  logic [LinkW-1:0]  lk_prev, lk_next, lk_head;
  logic              in_xfer, out_room;

  assign walk_end  = rd_start + rd_len;
  assign contains  = (rd_start <= item_q.addr) && (item_q.addr < walk_end);
  assign in_region = (item_q.addr <= rd_start) && (rd_start <= item_q.region_end);
  assign match     = (item_q.mode == MODE_REGION) ? in_region : contains;

  assign lk_prev = (item_q.mode == MODE_ALLOC) ? Nil : rd_prev;
  assign lk_next = rd_next;
  assign lk_head = (item_q.mode == MODE_ALLOC) ? alloc_head_q : free_head_q;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && (state_q == S_IDLE);
  assign out_room   = !out_valid_q || out_o.ready;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    alloc_head_d = alloc_head_q;
    free_head_d  = free_head_q;
    cur_d        = cur_q;
    status_d     = status_q;
    hit_d        = hit_q;
    busy_d       = busy_q;
    item_d       = item_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_item_d   = out_item_q;
    data_we      = 1'b0;
    next_we      = 1'b0;
    prev_we      = 1'b0;
    next_waddr   = cur_q[AddrW-1:0];
    prev_waddr   = cur_q[AddrW-1:0];
    next_wdata   = Nil;
    prev_wdata   = Nil;
    rd_en        = 1'b0;
    rd_addr      = cur_q[AddrW-1:0];

    unique case (state_q)
      S_CLEAR: begin
        next_we    = 1'b1;
        prev_we    = 1'b1;
        next_waddr = clr_q;
        prev_waddr = clr_q;
        next_wdata = LinkW'(clr_q) + LinkW'(1);
        prev_wdata = (clr_q == '0) ? Nil : LinkW'(clr_q) - LinkW'(1);
        if (clr_q == LastAddr) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AddrW'(1);
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          item_d   = in_i.payload;
          hit_d    = 1'b0;
          busy_d   = 1'b0;
          status_d = STAT_OK;
          if (in_i.payload.mode == MODE_ALLOC) begin
            cur_d = free_head_q;
            if (link_ok(free_head_q)) begin
              data_we = 1'b1;
              rd_en   = 1'b1;
              rd_addr = free_head_q[AddrW-1:0];
              hit_d   = 1'b1;
              state_d = S_LINK1;
            end else begin
              status_d = STAT_EXHAUSTED;
              state_d  = S_FINISH;
            end
          end else begin
            cur_d = alloc_head_q;
            if (link_ok(alloc_head_q)) begin
              rd_en   = 1'b1;
              rd_addr = alloc_head_q[AddrW-1:0];
              state_d = S_WALK;
            end else begin
              if (in_i.payload.mode == MODE_RELEASE) begin
                status_d = STAT_NOT_FOUND;
              end
              state_d = S_FINISH;
            end
          end
        end
      end

      S_WALK: begin
        if (match) begin
          hit_d  = 1'b1;
          busy_d = (item_q.mode == MODE_REGION);
          state_d = (item_q.mode == MODE_RELEASE) ? S_LINK1 : S_FINISH;
        end else if (link_ok(rd_next)) begin
          rd_en   = 1'b1;
          rd_addr = rd_next[AddrW-1:0];
          cur_d   = rd_next;
        end else begin
          if (item_q.mode == MODE_RELEASE) begin
            status_d = STAT_NOT_FOUND;
          end
          state_d = S_FINISH;
        end
      end

      S_LINK1: begin
        // Take the record out of its current list.
        if (link_ok(lk_prev)) begin
          next_we    = 1'b1;
          next_waddr = lk_prev[AddrW-1:0];
          next_wdata = lk_next;
        end else if (item_q.mode == MODE_ALLOC) begin
          free_head_d = lk_next;
        end else begin
          alloc_head_d = lk_next;
        end
        if (link_ok(lk_next)) begin
          prev_we    = 1'b1;
          prev_waddr = lk_next[AddrW-1:0];
          prev_wdata = lk_prev;
        end
        state_d = S_LINK2;
      end

      S_LINK2: begin
        next_we    = 1'b1;
        next_wdata = lk_head;
        prev_we    = 1'b1;
        prev_wdata = Nil;
        state_d    = S_LINK3;
      end

      S_LINK3: begin
        if (link_ok(lk_head)) begin
          prev_we    = 1'b1;
          prev_waddr = lk_head[AddrW-1:0];
          prev_wdata = cur_q;
        end
        if (item_q.mode == MODE_ALLOC) begin
          alloc_head_d = cur_q;
        end else begin
          free_head_d = cur_q;
        end
        state_d = S_FINISH;
      end

      S_FINISH: begin
        if (out_room) begin
          out_valid_d             = 1'b1;
          out_item_d.status       = status_q;
          out_item_d.hit          = hit_q;
          out_item_d.region_busy  = busy_q;
          out_item_d.chunk_index  = hit_q ? IndexW'(cur_q) : '0;
          if (!hit_q) begin
            out_item_d.found_start = '0;
            out_item_d.found_size  = '0;
          end else if (item_q.mode == MODE_ALLOC) begin
            out_item_d.found_start = item_q.addr;
            out_item_d.found_size  = item_q.chunk_size;
          end else begin
            out_item_d.found_start = rd_start;
            out_item_d.found_size  = rd_len;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      alloc_head_q <= Nil;
      free_head_q  <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= STAT_OK;
      hit_q        <= 1'b0;
      busy_q       <= 1'b0;
      cur_q        <= Nil;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      alloc_head_q <= alloc_head_d;
      free_head_q  <= free_head_d;
      out_valid_q  <= out_valid_d;
      status_q     <= status_d;
      hit_q        <= hit_d;
      busy_q       <= busy_d;
      cur_q        <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    out_item_q <= out_item_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

  art_mem #(.Depth(CHUNK_COUNT), .Width(WordW), .AddrW(AddrW)) u_start_mem (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (free_head_q[AddrW-1:0]),
    .wdata_i (in_i.payload.addr),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_start)
  );

  art_mem #(.Depth(CHUNK_COUNT), .Width(WordW), .AddrW(AddrW)) u_len_mem (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (free_head_q[AddrW-1:0]),
    .wdata_i (in_i.payload.chunk_size),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_len)
  );

  art_mem #(.Depth(CHUNK_COUNT), .Width(LinkW), .AddrW(AddrW)) u_next_mem (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_next)
  );

  art_mem #(.Depth(CHUNK_COUNT), .Width(LinkW), .AddrW(AddrW)) u_prev_mem (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_prev)
  );
endmodule

FILE: rtl/art_mem.sv
module art_mem #(
  parameter int Depth = 64,
  parameter int Width = 64,
  parameter int AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
